// ===== rtl/mmwd_pkg.sv =====
package mmwd_pkg;

    // group and panel sizing
    localparam int SAMPLES_PER_COLUMN = 8;
    localparam int COLUMNS            = 128;

    localparam int CNT_W    = (SAMPLES_PER_COLUMN > 1) ? $clog2(SAMPLES_PER_COLUMN) : 1;
    localparam int PTR_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int SAMPLE_W = 16;
    localparam int ROW_W    = 14;
    localparam int COL_W    = 7;
    localparam int CFG_W    = 6;
    localparam int CFG_IDX_W = 2;

    // register reset values
    localparam logic [CFG_W-1:0] TRACE_TOP_RESET    = 6'd16;
    localparam logic [CFG_W-1:0] TRACE_BOTTOM_RESET = 6'd54;
    localparam logic [CFG_W-1:0] MAX_DEV_RESET      = 6'd20;

    // op codes
    localparam logic OP_PUSH    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRACE_TOP    = 2'd0,
        CFG_TRACE_BOTTOM = 2'd1,
        CFG_MAX_DEV      = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_PIXEL = 2'd1,
        MARK_LINE  = 2'd2
    } mark_t;

    typedef struct packed {
        logic [CFG_W-1:0] top_row;
        logic [CFG_W-1:0] bottom_row;
        logic [CFG_W-1:0] max_dev;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] min_val;
        logic signed [SAMPLE_W-1:0] max_val;
        logic [COL_W-1:0]           col;
    } group_t;

    // low column bits of the wrapping pointer
    function automatic logic [COL_W-1:0] col_of(input logic [PTR_W-1:0] ptr);
        logic [PTR_W+COL_W-1:0] ext;
        begin
            ext = (PTR_W+COL_W)'(ptr);
            return ext[COL_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/mmwd_tracker.sv =====
module mmwd_tracker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   op,
    input  logic signed [mmwd_pkg::SAMPLE_W-1:0]   sample,
    output logic                                   grp_valid,
    output mmwd_pkg::group_t                       grp,
    input  logic                                   grp_ready
);
    import mmwd_pkg::*;

    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [PTR_W-1:0]           ptr_reg, ptr_next;
    logic                       grp_valid_reg, grp_valid_next;
    group_t                     grp_reg;
    logic                       accept;
    logic                       push;
    logic                       restart;
    logic                       first;
    logic                       last;
    logic signed [SAMPLE_W-1:0] upd_min;
    logic signed [SAMPLE_W-1:0] upd_max;

    // a pending group only blocks when the row stage cannot take it
    assign in_stall = grp_valid_reg && !grp_ready;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && (op == OP_PUSH);
    assign restart  = accept && (op == OP_RESTART);
    assign first    = (cnt_reg == '0);
    assign last     = (cnt_reg == CNT_W'(SAMPLES_PER_COLUMN - 1));

    assign upd_min = (first || (sample < min_reg)) ? sample : min_reg;
    assign upd_max = (first || (sample > max_reg)) ? sample : max_reg;

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        if (restart)
        begin
            min_next = '0;
            max_next = '0;
            cnt_next = '0;
            ptr_next = '0;
        end
        else if (push)
        begin
            min_next = upd_min;
            max_next = upd_max;
            cnt_next = last ? '0 : cnt_reg + 1'b1;
            if (last)
            begin
                ptr_next = (ptr_reg == PTR_W'(COLUMNS - 1)) ? '0 : ptr_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (push && last)
        begin
            grp_valid_next = 1'b1;
        end
        else if (grp_ready)
        begin
            grp_valid_next = 1'b0;
        end
        else
        begin
            grp_valid_next = grp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= '0;
            max_reg       <= '0;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            grp_valid_reg <= 1'b0;
        end
        else
        begin
            min_reg       <= min_next;
            max_reg       <= max_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            grp_valid_reg <= grp_valid_next;
        end
    end

    // finished group, loaded with the closing sample folded in
    always_ff @(posedge clk)
    begin
        if (push && last)
        begin
            grp_reg.min_val <= upd_min;
            grp_reg.max_val <= upd_max;
            grp_reg.col     <= col_of(ptr_reg);
        end
    end

    assign grp_valid = grp_valid_reg;
    assign grp       = grp_reg;

endmodule

// ===== rtl/mmwd_rows.sv =====
module mmwd_rows (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 grp_valid,
    input  mmwd_pkg::group_t                     grp,
    output logic                                 grp_ready,
    input  mmwd_pkg::cfg_t                       cfg,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [mmwd_pkg::COL_W-1:0]           column_index,
    output logic signed [mmwd_pkg::SAMPLE_W-1:0] group_min,
    output logic signed [mmwd_pkg::SAMPLE_W-1:0] group_max,
    output logic signed [mmwd_pkg::ROW_W-1:0]    row_top,
    output logic signed [mmwd_pkg::ROW_W-1:0]    row_bottom,
    output logic [1:0]                           mark
);
    import mmwd_pkg::*;

    localparam int CALC_W = ROW_W + 1;
    localparam int PROD_W = SAMPLE_W + 2;

    logic                       out_valid_reg, out_valid_next;
    logic [COL_W-1:0]           col_reg;
    logic signed [SAMPLE_W-1:0] min_reg;
    logic signed [SAMPLE_W-1:0] max_reg;
    logic signed [ROW_W-1:0]    top_reg;
    logic signed [ROW_W-1:0]    bot_reg;
    mark_t                      mark_reg;
    logic                       load;

    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic signed [PROD_W-1:0]   prod_hi;
    logic signed [PROD_W-1:0]   prod_lo;
    logic [CFG_W:0]             mid_sum;
    logic signed [CALC_W-1:0]   mid_s;
    logic signed [CALC_W-1:0]   dev_s;
    logic signed [CALC_W-1:0]   box_top_s;
    logic signed [CALC_W-1:0]   box_bot_s;
    logic signed [CALC_W-1:0]   y0;
    logic signed [CALC_W-1:0]   y1;
    logic signed [CALC_W-1:0]   y_tmp;
    logic                       empty;
    mark_t                      mark_calc;

    assign grp_ready = !out_valid_reg || !out_stall;
    assign load      = grp_valid && grp_ready;

    assign mid_sum   = {1'b0, cfg.top_row} + {1'b0, cfg.bottom_row};
    assign mid_s     = $signed(CALC_W'(mid_sum[CFG_W:1]));
    assign dev_s     = $signed(CALC_W'(cfg.max_dev));
    assign box_top_s = $signed(CALC_W'(cfg.top_row));
    assign box_bot_s = $signed(CALC_W'(cfg.bottom_row));
    assign empty     = (grp.min_val == '0) && (grp.max_val == '0);

    always_comb
    begin
        lo = grp.min_val;
        hi = grp.max_val;
        if (lo > hi)
        begin
            lo = grp.max_val;
            hi = grp.min_val;
        end
        // v*3 as 2v + v, floor by dropping four bits
        prod_hi = {hi[SAMPLE_W-1], hi, 1'b0} + {{2{hi[SAMPLE_W-1]}}, hi};
        prod_lo = {lo[SAMPLE_W-1], lo, 1'b0} + {{2{lo[SAMPLE_W-1]}}, lo};
        y0 = mid_s - CALC_W'($signed(prod_hi[PROD_W-1:4]));
        y1 = mid_s - CALC_W'($signed(prod_lo[PROD_W-1:4]));
        if (y0 < mid_s - dev_s)
        begin
            y0 = mid_s - dev_s;
        end
        if (y1 > mid_s + dev_s)
        begin
            y1 = mid_s + dev_s;
        end
        if (y0 < box_top_s)
        begin
            y0 = box_top_s;
        end
        if (y1 > box_bot_s)
        begin
            y1 = box_bot_s;
        end
        y_tmp = y0;
        if (y0 > y1)
        begin
            y0 = y1;
            y1 = y_tmp;
        end
        if (empty)
        begin
            y0        = '0;
            y1        = '0;
            mark_calc = MARK_EMPTY;
        end
        else if (y0 == y1)
        begin
            mark_calc = MARK_PIXEL;
        end
        else
        begin
            mark_calc = MARK_LINE;
        end
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col_reg  <= grp.col;
            min_reg  <= grp.min_val;
            max_reg  <= grp.max_val;
            top_reg  <= y0[ROW_W-1:0];
            bot_reg  <= y1[ROW_W-1:0];
            mark_reg <= mark_calc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign column_index = col_reg;
    assign group_min    = min_reg;
    assign group_max    = max_reg;
    assign row_top      = top_reg;
    assign row_bottom   = bot_reg;
    assign mark         = mark_reg;

endmodule

// ===== rtl/min_max_waveform_decimator_unit.sv =====
// min/max waveform decimator for a display trace
//
// input channel (in_valid / in_stall, op, sample): one transfer per cycle at most;
//   op push folds a signed sample into the running min and max of the current group,
//   op restart clears tracker, group counter and column pointer and gives no result
// output channel (out_valid / out_stall): one transfer per finished group, carrying
//   the column index, raw group min/max, segment rows and the column mark
// config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): always ready, writes
//   trace top row, trace bottom row and deviation band; the user must write only
//   while the block is idle, which the block itself does not enforce
// throughput: one item per cycle unless in_stall, set by the single compare-update
//   of the tracker; the group register loads at the edge accepting a group-closing
//   transfer, and the row result enters the output register once that is free
// stall: a held result waits in the output register while a second group may wait in
//   the group register; in_stall rises only when both are occupied
// reset: tracker state clears, registers return to top 16, bottom 54, band 20,
//   and both result stages empty
module min_max_waveform_decimator_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  op,
    input  logic signed [mmwd_pkg::SAMPLE_W-1:0]  sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [mmwd_pkg::COL_W-1:0]            column_index,
    output logic signed [mmwd_pkg::SAMPLE_W-1:0]  group_min,
    output logic signed [mmwd_pkg::SAMPLE_W-1:0]  group_max,
    output logic signed [mmwd_pkg::ROW_W-1:0]     row_top,
    output logic signed [mmwd_pkg::ROW_W-1:0]     row_bottom,
    output logic [1:0]                            mark,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mmwd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mmwd_pkg::CFG_W-1:0]            cfg_data
);
    import mmwd_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    logic   grp_valid;
    logic   grp_ready;
    group_t grp;

    // register file: writes to an unused index are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TRACE_TOP:    cfg_next.top_row    = cfg_data;
                CFG_TRACE_BOTTOM: cfg_next.bottom_row = cfg_data;
                CFG_MAX_DEV:      cfg_next.max_dev    = cfg_data;
                default:          cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.top_row    <= TRACE_TOP_RESET;
            cfg_reg.bottom_row <= TRACE_BOTTOM_RESET;
            cfg_reg.max_dev    <= MAX_DEV_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // running min/max over the group, column pointer
    mmwd_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .sample    (sample),
        .grp_valid (grp_valid),
        .grp       (grp),
        .grp_ready (grp_ready)
    );

    // scaling, band and box clamp, ordering, mark; feeds the output register
    mmwd_rows u_rows (
        .clk          (clk),
        .rst_n        (rst_n),
        .grp_valid    (grp_valid),
        .grp          (grp),
        .grp_ready    (grp_ready),
        .cfg          (cfg_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .column_index (column_index),
        .group_min    (group_min),
        .group_max    (group_max),
        .row_top      (row_top),
        .row_bottom   (row_bottom),
        .mark         (mark)
    );

endmodule

// ===== rtl/mmwd_checker.sv =====
module mmwd_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic [mmwd_pkg::COL_W-1:0]            column_index,
    input logic signed [mmwd_pkg::SAMPLE_W-1:0]  group_min,
    input logic signed [mmwd_pkg::SAMPLE_W-1:0]  group_max,
    input logic signed [mmwd_pkg::ROW_W-1:0]     row_top,
    input logic signed [mmwd_pkg::ROW_W-1:0]     row_bottom,
    input logic [1:0]                            mark
);
    import mmwd_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(group_min)
            && $stable(row_top) && $stable(row_bottom) && $stable(column_index))
        else $error("stalled result changed");

    // empty column carries zero rows
    a_empty_rows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mark == MARK_EMPTY) |-> (row_top == '0) && (row_bottom == '0)
            && (group_min == '0) && (group_max == '0))
        else $error("empty column with non-zero rows");

    // mark agrees with the ordered segment
    a_mark_rows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((mark == MARK_PIXEL) && (row_top == row_bottom))
            || ((mark == MARK_LINE) && (row_top < row_bottom))
            || (mark == MARK_EMPTY))
        else $error("mark does not match segment rows");

    // tracker keeps min below max
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> group_min <= group_max)
        else $error("group min above group max");

endmodule

bind min_max_waveform_decimator_unit mmwd_checker u_mmwd_checker (.*);

// ===== tb/decimator_column_checker.sv =====
`timescale 1ns / 100ps

module decimator_column_checker
    import mmwd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       op,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [COL_W-1:0]           column_index,
    input  logic signed [SAMPLE_W-1:0] group_min,
    input  logic signed [SAMPLE_W-1:0] group_max,
    input  logic signed [ROW_W-1:0]    row_top,
    input  logic signed [ROW_W-1:0]    row_bottom,
    input  logic [1:0]                 mark,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    output int                         mismatches,
    output int                         columns_pending,
    output int                         columns_checked,
    output int                         empty_columns,
    output int                         pixel_columns
);

    typedef struct packed {
        logic [COL_W-1:0]           col;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        logic signed [ROW_W-1:0]    top;
        logic signed [ROW_W-1:0]    bot;
        mark_t                      mk;
    } column_t;

    localparam int REPORT_CAP = 40;

    cfg_t                       panel;
    logic signed [SAMPLE_W-1:0] run_min;
    logic signed [SAMPLE_W-1:0] run_max;
    int                         fill;
    int                         col_ptr;
    column_t                    expected_columns[$];
    int                         errors;
    int                         checked;
    int                         empties;
    int                         pixels;

    // display column for a finished group under the current panel registers
    function automatic column_t segment_of(input logic signed [SAMPLE_W-1:0] lo_s,
                                           input logic signed [SAMPLE_W-1:0] hi_s,
                                           input int ptr, input cfg_t p);
        column_t c;
        int      lo;
        int      hi;
        int      mid;
        int      dev;
        int      y0;
        int      y1;
        int      t;
        c.col = COL_W'(ptr);
        c.lo  = lo_s;
        c.hi  = hi_s;
        c.top = '0;
        c.bot = '0;
        c.mk  = MARK_EMPTY;
        if (lo_s != 0 || hi_s != 0)
        begin
            lo = lo_s;
            hi = hi_s;
            if (lo > hi)
            begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            mid = (int'(p.top_row) + int'(p.bottom_row)) / 2;
            dev = int'(p.max_dev);
            // floor shift of the scaled sample
            y0 = mid - ((hi * 3) >>> 4);
            y1 = mid - ((lo * 3) >>> 4);
            if (y0 < mid - dev)
                y0 = mid - dev;
            if (y1 > mid + dev)
                y1 = mid + dev;
            if (y0 < int'(p.top_row))
                y0 = int'(p.top_row);
            if (y1 > int'(p.bottom_row))
                y1 = int'(p.bottom_row);
            if (y0 > y1)
            begin
                t  = y0;
                y0 = y1;
                y1 = t;
            end
            c.top = ROW_W'(y0);
            c.bot = ROW_W'(y1);
            c.mk  = (y0 == y1) ? MARK_PIXEL : MARK_LINE;
        end
        return c;
    endfunction

    function automatic int field_differs(input string name, input logic signed [31:0] want,
                                         input logic signed [31:0] got);
        if (got !== want)
        begin
            if (errors < REPORT_CAP)
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        column_t want;
        int      bad;
        if (!rst_n)
        begin
            panel   = '{top_row: TRACE_TOP_RESET, bottom_row: TRACE_BOTTOM_RESET,
                        max_dev: MAX_DEV_RESET};
            run_min = '0;
            run_max = '0;
            fill    = 0;
            col_ptr = 0;
            expected_columns.delete();
            errors  = 0;
            checked = 0;
            empties = 0;
            pixels  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TRACE_TOP:    panel.top_row    = cfg_data;
                    CFG_TRACE_BOTTOM: panel.bottom_row = cfg_data;
                    CFG_MAX_DEV:      panel.max_dev    = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                if (op == OP_RESTART)
                begin
                    run_min = '0;
                    run_max = '0;
                    fill    = 0;
                    col_ptr = 0;
                end
                else
                begin
                    if (fill == 0 || sample < run_min)
                        run_min = sample;
                    if (fill == 0 || sample > run_max)
                        run_max = sample;
                    fill++;
                    if (fill == SAMPLES_PER_COLUMN)
                    begin
                        fill = 0;
                        expected_columns.push_back(segment_of(run_min, run_max, col_ptr, panel));
                        col_ptr = (col_ptr == COLUMNS - 1) ? 0 : col_ptr + 1;
                    end
                end
            end

            if (out_valid && !out_stall)
            begin
                if (expected_columns.size() == 0)
                begin
                    if (errors < REPORT_CAP)
                        $display("%0t: column transfer with none expected, index %0d min %0d max %0d",
                                 $time, column_index, group_min, group_max);
                    errors++;
                end
                else
                begin
                    want = expected_columns.pop_front();
                    bad  = field_differs("column_index", want.col, column_index)
                         + field_differs("group_min", want.lo, group_min)
                         + field_differs("group_max", want.hi, group_max)
                         + field_differs("row_top", want.top, row_top)
                         + field_differs("row_bottom", want.bot, row_bottom)
                         + field_differs("mark", want.mk, mark);
                    if (bad != 0)
                        errors++;
                    checked++;
                    if (want.mk == MARK_EMPTY)
                        empties++;
                    else if (want.mk == MARK_PIXEL)
                        pixels++;
                end
            end
        end
        mismatches      <= errors;
        columns_pending <= expected_columns.size();
        columns_checked <= checked;
        empty_columns   <= empties;
        pixel_columns   <= pixels;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import mmwd_pkg::*;

    // settle after the last column: two result stages plus margin
    localparam int SETTLE_CYCLES = 4;
    // cycles with no transfer on any channel before the run is abandoned
    localparam int HANG_LIMIT    = 5000;

    // corner samples: both rails, alternating bit patterns, unit steps about zero
    localparam logic signed [SAMPLE_W-1:0] CORNERS [8] = '{16'sh7FFF, 16'sh8000, 16'sh5555,
        16'shAAAA, 16'sh0001, 16'shFFFF, 16'sh0000, 16'sh0064};

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_mode_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid;
    logic                       out_stall;
    logic [COL_W-1:0]           column_index;
    logic signed [SAMPLE_W-1:0] group_min;
    logic signed [SAMPLE_W-1:0] group_max;
    logic signed [ROW_W-1:0]    row_top;
    logic signed [ROW_W-1:0]    row_bottom;
    logic [1:0]                 mark;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;

    int mismatches;
    int columns_pending;
    int columns_checked;
    int empty_columns;
    int pixel_columns;

    // sender bookkeeping
    int burst_left;
    int items_sent;
    int restarts_sent;
    int settings_written;

    // receiver stall pattern
    stall_mode_t stall_mode;
    int          stall_window;
    int          stall_beat;
    int          beat_len;

    int idle_cycles;

    min_max_waveform_decimator_unit dut (.*);

    decimator_column_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // one input transfer: payload held until accepted, then either carry on with the
    // burst or drop valid for a random gap so that gaps land on every group position
    task automatic send(input logic o, input logic signed [SAMPLE_W-1:0] s);
        in_valid <= 1'b1;
        op       <= o;
        sample   <= s;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (o == OP_RESTART)
            restarts_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3))
                @(posedge clk);
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // register write; valid stays high across back-to-back writes
    task automatic cfg_write(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_panel(input logic [CFG_W-1:0] top, input logic [CFG_W-1:0] bot,
                             input logic [CFG_W-1:0] dev);
        cfg_write(CFG_TRACE_TOP, top);
        cfg_write(CFG_TRACE_BOTTOM, bot);
        cfg_write(CFG_MAX_DEV, dev);
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    // stop sending and wait until every predicted column has come out, then let the
    // pipeline settle so that registers are only touched while the block is idle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (columns_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random traffic shaped by group: each group of samples gets one flavour so that
    // empty, single pixel, clamped and unclamped columns all turn up; restarts are noise
    task automatic run_traffic(input int count, input int restart_odds);
        int                         in_group;
        int                         flavour;
        logic signed [SAMPLE_W-1:0] level;
        logic signed [SAMPLE_W-1:0] s;
        in_group = 0;
        flavour  = 0;
        level    = '0;
        for (int n = 0; n < count; n++)
        begin
            if (restart_odds != 0 && $urandom_range(1, restart_odds) == 1)
            begin
                send(OP_RESTART, SAMPLE_W'($urandom));
                in_group = 0;
            end
            else
            begin
                if (in_group == 0)
                begin
                    flavour = $urandom_range(0, 5);
                    level   = SAMPLE_W'($urandom_range(0, 40) - 20);
                end
                case (flavour)
                    0, 1:    s = SAMPLE_W'($urandom);
                    2:       s = SAMPLE_W'($urandom_range(0, 200) - 100);
                    3:       s = '0;
                    4:       s = level;
                    default: s = ($urandom_range(0, 1) == 1) ? SAMPLE_W'(32767 - $urandom_range(0, 3))
                                                              : SAMPLE_W'(-32768 + $urandom_range(0, 3));
                endcase
                send(OP_PUSH, s);
                in_group = (in_group + 1) % SAMPLES_PER_COLUMN;
            end
        end
    endtask

    // receiver: stall pattern changes every window, from none at all through light and
    // heavy random stalling to a regular beat of stalled and free stretches
    initial
    begin
        out_stall    = 1'b0;
        stall_mode   = STALL_NONE;
        stall_window = 0;
        stall_beat   = 0;
        beat_len     = 1;
        forever
        begin
            @(posedge clk);
            if (stall_window == 0)
            begin
                stall_mode   = stall_mode_t'($urandom_range(0, 3));
                stall_window = $urandom_range(20, 80);
                beat_len     = $urandom_range(1, 12);
            end
            stall_window--;
            stall_beat++;
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= (((stall_beat / beat_len) % 2) == 1);
            endcase
        end
    end

    // watchdog: counts cycles in which no channel completes a transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles == HANG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, giving up", $time, HANG_LIMIT);
            $display("** min_max_waveform_decimator_unit: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        op               = OP_PUSH;
        sample           = '0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_TRACE_TOP;
        cfg_data         = '0;
        burst_left       = 0;
        items_sent       = 0;
        restarts_sent    = 0;
        settings_written = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset registers (box 16..54, band 20)
        // restart straight out of reset
        send(OP_RESTART, 16'sh8000);
        // all-zero group gives an empty column
        repeat (SAMPLES_PER_COLUMN) send(OP_PUSH, '0);
        // both rails and alternating patterns: rows clamped to band and box
        foreach (CORNERS[i])
            send(OP_PUSH, CORNERS[i]);
        // part of a group, then restart: nothing comes out and the pointer goes back
        send(OP_PUSH, 16'sh7FFF);
        send(OP_PUSH, 16'sh8000);
        send(OP_PUSH, 16'sh1234);
        send(OP_RESTART, 16'sh0000);
        // small constant level scales to zero rows, so a single pixel on the mid row
        repeat (SAMPLES_PER_COLUMN) send(OP_PUSH, 16'sh0005);
        run_traffic(110, 0);
        drain();

        // corners of the box and band: full box, inverted box, inverted with no band,
        // everything zero, everything at the top, zero band, back to reset values;
        // no restarts yet, so the column pointer keeps running across these settings
        set_panel(6'd0, 6'd63, 6'd63);
        run_traffic(110, 0);
        drain();
        set_panel(6'd63, 6'd0, 6'd63);
        run_traffic(110, 0);
        drain();
        set_panel(6'd63, 6'd0, 6'd0);
        run_traffic(110, 0);
        drain();
        set_panel(6'd0, 6'd0, 6'd0);
        run_traffic(110, 0);
        drain();
        set_panel(6'd63, 6'd63, 6'd63);
        run_traffic(110, 0);
        drain();
        set_panel(6'd0, 6'd63, 6'd0);
        run_traffic(110, 0);
        drain();
        set_panel(TRACE_TOP_RESET, TRACE_BOTTOM_RESET, MAX_DEV_RESET);
        run_traffic(110, 0);
        drain();

        // random settings, the later ones with restarts mixed in
        for (int ph = 0; ph < 6; ph++)
        begin
            set_panel(CFG_W'($urandom_range(0, 63)), CFG_W'($urandom_range(0, 63)),
                      CFG_W'($urandom_range(0, 63)));
            run_traffic((ph < 2) ? 110 : 80, (ph < 2) ? 0 : 30);
            drain();
        end

        $display("run covered %0d input transfers including %0d restarts, over %0d register settings",
                 items_sent, restarts_sent, settings_written + 1);
        $display("%0d columns compared field by field, %0d of them empty and %0d single pixel",
                 columns_checked, empty_columns, pixel_columns);
        if (mismatches == 0 && columns_pending == 0)
            $display("** min_max_waveform_decimator_unit: PASSED **");
        else
            $display("** min_max_waveform_decimator_unit: FAILED **");
        $finish;
    end

endmodule
